### sv/lcfd_pkg.sv
// Package for the load-cell frame decoder and fuser.
// Holds shared constants, the error code type and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcfd_pkg;

	// Default number of sensor slots.
	localparam int MAX_SENSORS_DEF = 4;

	// Width of one data sample.
	localparam int DATA_BITS = 24;

	// Fused result width.
	localparam int RES_W = 25;

	// Quotient bits the divider resolves per cycle.
	localparam int DIGIT_BITS = 4;

	// Configuration port address width and register indexes.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_GAIN    = 2'd0;
	localparam logic [1:0] REG_SENSORS = 2'd1;
	localparam logic [1:0] REG_INVERT  = 2'd2;
	localparam logic [1:0] REG_PROBE   = 2'd3;

	// Report words for the two error kinds.
	localparam logic [31:0] WORD_DESYNC   = 32'h8000_0000;
	localparam logic [31:0] WORD_TOO_LONG = 32'h4000_0000;

	// Per-sensor error code.
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DESYNC   = 2'd1,
		ERR_TOO_LONG = 2'd2
	} err_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [2:0] gain_setting;
		logic [2:0] sensors_in_use;
		logic [3:0] invert_mask;
		logic       probe_enable;
	} cfg_t;

endpackage

`default_nettype wire

### sv/lcfd_if.sv
// Handshake interfaces for the frame input channel and the report output channel.
// Depends on nothing but the standard valid/ready convention.
`timescale 1ns / 1ps
`default_nettype none

interface lcfd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [1:0]  sensor_index;
	logic [27:0] raw_frame;
	logic        overran;
	logic        end_of_round;

	modport source (output valid, func, sensor_index, raw_frame, overran, end_of_round,
		input ready);
	modport sink (input valid, func, sensor_index, raw_frame, overran, end_of_round,
		output ready);
endinterface

interface lcfd_out_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] sample_value;
	logic [1:0]         error_code;
	logic [31:0]        report_word;
	logic               probe_valid;

	modport source (output valid, sample_value, error_code, report_word, probe_valid,
		input ready);
	modport sink (input valid, sample_value, error_code, report_word, probe_valid,
		output ready);
endinterface

`default_nettype wire

### sv/lcfd_apb_regs.sv
// APB-style configuration register file for the frame decoder.
// Depends on lcfd_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module lcfd_apb_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [lcfd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output lcfd_pkg::cfg_t                 cfg
);

	logic           wr_en;
	logic [1:0]     reg_idx;
	lcfd_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_setting   <= 3'd1;
			cfg_q.sensors_in_use <= 3'd1;
			cfg_q.invert_mask    <= 4'd0;
			cfg_q.probe_enable   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				lcfd_pkg::REG_GAIN:    cfg_q.gain_setting   <= pwdata[2:0];
				lcfd_pkg::REG_SENSORS: cfg_q.sensors_in_use <= pwdata[2:0];
				lcfd_pkg::REG_INVERT:  cfg_q.invert_mask    <= pwdata[3:0];
				lcfd_pkg::REG_PROBE:   cfg_q.probe_enable   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			lcfd_pkg::REG_GAIN:    prdata = {29'd0, cfg_q.gain_setting};
			lcfd_pkg::REG_SENSORS: prdata = {29'd0, cfg_q.sensors_in_use};
			lcfd_pkg::REG_INVERT:  prdata = {28'd0, cfg_q.invert_mask};
			lcfd_pkg::REG_PROBE:   prdata = {31'd0, cfg_q.probe_enable};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### sv/lcfd_sensor_bank.sv
// Frame decode and per-sensor sample and error storage.
// Depends on lcfd_pkg for the error codes and the data width.
`timescale 1ns / 1ps
`default_nettype none

module lcfd_sensor_bank #(
	parameter int MAX_SENSORS = lcfd_pkg::MAX_SENSORS_DEF,
	parameter int IDX_W       = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              clr,
	input  wire logic [1:0]        wr_index,
	input  wire logic [27:0]       raw_frame,
	input  wire logic              overran,
	input  wire logic [2:0]        gain_setting,
	input  wire logic [IDX_W-1:0]  rd_index,
	output logic [lcfd_pkg::DATA_BITS-1:0] rd_sample,
	output lcfd_pkg::err_t         rd_err
);

	logic [lcfd_pkg::DATA_BITS-1:0] sample_q [MAX_SENSORS];
	lcfd_pkg::err_t                 err_q    [MAX_SENSORS];
	logic [lcfd_pkg::DATA_BITS-1:0] dec_sample;
	logic                           dec_sync;
	logic                           slot_ok;
	logic [IDX_W-1:0]               slot;

	// Pick the data bits and check the trailing gain bits; gain is clamped to 1..4.
	always_comb begin
		case (gain_setting)
			3'd2: begin
				dec_sample = raw_frame[25:2];
				dec_sync   = &raw_frame[1:0];
			end
			3'd3: begin
				dec_sample = raw_frame[26:3];
				dec_sync   = &raw_frame[2:0];
			end
			3'd0, 3'd1: begin
				dec_sample = raw_frame[24:1];
				dec_sync   = raw_frame[0];
			end
			default: begin
				dec_sample = raw_frame[27:4];
				dec_sync   = &raw_frame[3:0];
			end
		endcase
	end

	assign slot_ok = (32'(wr_index) < MAX_SENSORS);
	assign slot    = IDX_W'(wr_index);

	// Store the decoded frame; the newest error wins, a clean frame keeps an old one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				sample_q[i] <= '0;
				err_q[i]    <= lcfd_pkg::ERR_NONE;
			end
		end else if (clr) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				sample_q[i] <= '0;
				err_q[i]    <= lcfd_pkg::ERR_NONE;
			end
		end else if (wr_en && slot_ok) begin
			sample_q[slot] <= dec_sample;
			if (!dec_sync) begin
				err_q[slot] <= lcfd_pkg::ERR_DESYNC;
			end else if (overran) begin
				err_q[slot] <= lcfd_pkg::ERR_TOO_LONG;
			end
		end
	end

	assign rd_sample = sample_q[rd_index];
	assign rd_err    = err_q[rd_index];

endmodule

`default_nettype wire

### sv/lcfd_divider.sv
// Iterative unsigned divider, four quotient bits per cycle, for the fused average.
// Depends on lcfd_pkg for the digit width.
`timescale 1ns / 1ps
`default_nettype none

module lcfd_divider #(
	parameter int DIV_W = 28,
	parameter int N_W   = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [N_W-1:0]   divisor,
	output logic                  busy,
	output logic [DIV_W-1:0]      quotient
);

	localparam int DIGITS = DIV_W / lcfd_pkg::DIGIT_BITS;
	localparam int CNT_W  = $clog2(DIGITS + 1);

	logic [DIV_W-1:0] dq_q;
	logic [N_W-1:0]   rem_q;
	logic [N_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIV_W-1:0] dq_nx;
	logic [N_W-1:0]   rem_nx;
	logic [N_W:0]     trial;

	// Four restoring steps: dividend bits leave at the top, quotient bits enter at the bottom.
	always_comb begin
		dq_nx  = dq_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < lcfd_pkg::DIGIT_BITS; k++) begin
			trial = {rem_nx, dq_nx[DIV_W-1]};
			dq_nx = {dq_nx[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				dq_nx[0] = 1'b1;
			end
			rem_nx = trial[N_W-1:0];
		end
	end

	// Sequencing of the digit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIGITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= dq_nx;
			rem_q <= rem_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

### sv/load_cell_frame_decode_fuse_top.sv
// Load-cell frame decoder and fuser, top level.
// A frame without end_of_round is stored, and a restart clears the bank; neither makes a report.
// A frame with end_of_round runs the slot scan through one shared adder (n sensors fused),
// then the divider that resolves four quotient bits a cycle; an error report skips the
// divider.
// One item at a time; a waiting report holds the finish step. Reset clears all state but the divider datapath.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_frame_decode_fuse_top #(
	parameter int MAX_SENSORS = lcfd_pkg::MAX_SENSORS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lcfd_in_if.sink                          in_ch,
	lcfd_out_if.source                       out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lcfd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	localparam int IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int N_W    = $clog2(MAX_SENSORS + 1);
	localparam int SUM_W  = lcfd_pkg::DATA_BITS + 1 + $clog2(MAX_SENSORS);
	localparam int DIGITS = (SUM_W + lcfd_pkg::DIGIT_BITS - 1) / lcfd_pkg::DIGIT_BITS;
	localparam int DIV_W  = DIGITS * lcfd_pkg::DIGIT_BITS;
	localparam int RES_W  = lcfd_pkg::RES_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_START,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	lcfd_pkg::cfg_t                 cfg;
	logic                           in_acc;
	logic [N_W-1:0]                 scan_q;
	logic [N_W-1:0]                 n_eff;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [SUM_W-1:0]        sum_nx;
	logic signed [SUM_W-1:0]        samp_ext;
	lcfd_pkg::err_t                 err_q;
	lcfd_pkg::err_t                 err_nx;
	lcfd_pkg::err_t                 rd_err;
	logic [lcfd_pkg::DATA_BITS-1:0] rd_sample;
	logic [7:0]                     mask_ext;
	logic                           inv;
	logic                           neg_q;
	logic [SUM_W-1:0]               mag;
	logic                           div_start;
	logic                           div_busy;
	logic [DIV_W-1:0]               div_quot;
	logic signed [RES_W-1:0]        fused;
	logic                           out_valid_q;
	logic signed [RES_W-1:0]        out_sample_q;
	logic [1:0]                     out_code_q;
	logic [31:0]                    out_word_q;
	logic                           out_probe_q;
	logic                           out_free;

	lcfd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	lcfd_sensor_bank #(
		.MAX_SENSORS (MAX_SENSORS),
		.IDX_W       (IDX_W)
	) u_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (in_acc && !in_ch.func),
		.clr          (in_acc && in_ch.func),
		.wr_index     (in_ch.sensor_index),
		.raw_frame    (in_ch.raw_frame),
		.overran      (in_ch.overran),
		.gain_setting (cfg.gain_setting),
		.rd_index     (scan_q[IDX_W-1:0]),
		.rd_sample    (rd_sample),
		.rd_err       (rd_err)
	);

	// Number of fused slots, clamped to 1..MAX_SENSORS.
	always_comb begin
		if (cfg.sensors_in_use == 3'd0) begin
			n_eff = N_W'(1);
		end else if (32'(cfg.sensors_in_use) > MAX_SENSORS) begin
			n_eff = N_W'(MAX_SENSORS);
		end else begin
			n_eff = N_W'(cfg.sensors_in_use);
		end
	end

	// Shared accumulate step: add or subtract one slot, keep the first error in slot order.
	assign mask_ext = {4'd0, cfg.invert_mask};
	assign inv      = mask_ext[3'(scan_q)];
	assign samp_ext = {{(SUM_W - lcfd_pkg::DATA_BITS){rd_sample[lcfd_pkg::DATA_BITS-1]}},
		rd_sample};
	assign sum_nx   = inv ? (sum_q - samp_ext) : (sum_q + samp_ext);
	assign err_nx   = (err_q == lcfd_pkg::ERR_NONE) ? rd_err : err_q;

	// Magnitude of the sum for the divider.
	assign mag       = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
	assign div_start = (state_q == ST_START) && (err_q == lcfd_pkg::ERR_NONE);

	lcfd_divider #(
		.DIV_W (DIV_W),
		.N_W   (N_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(mag)),
		.divisor  (n_eff),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// Signed result, truncated toward zero.
	assign fused    = neg_q ? (RES_W'(0) - $signed(div_quot[RES_W-1:0]))
		: $signed(div_quot[RES_W-1:0]);
	assign out_free = !out_valid_q || out_ch.ready;

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			scan_q       <= '0;
			err_q        <= lcfd_pkg::ERR_NONE;
			sum_q        <= '0;
			neg_q        <= 1'b0;
			out_sample_q <= '0;
			out_code_q   <= lcfd_pkg::ERR_NONE;
			out_word_q   <= '0;
			out_probe_q  <= 1'b0;
		end else begin
			// The finish step reloads the register itself when the word is taken.
			if (out_valid_q && out_ch.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !in_ch.func && in_ch.end_of_round) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						sum_q   <= '0;
						err_q   <= lcfd_pkg::ERR_NONE;
					end
				end
				ST_SCAN: begin
					sum_q  <= sum_nx;
					err_q  <= err_nx;
					scan_q <= scan_q + 1'b1;
					if (scan_q == n_eff - 1'b1) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					neg_q   <= sum_q[SUM_W-1];
					state_q <= (err_q == lcfd_pkg::ERR_NONE) ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (err_q == lcfd_pkg::ERR_NONE) begin
							out_sample_q <= fused;
							out_code_q   <= lcfd_pkg::ERR_NONE;
							out_word_q   <= {{(32 - RES_W){fused[RES_W-1]}}, fused};
							out_probe_q  <= cfg.probe_enable;
						end else begin
							out_sample_q <= '0;
							out_code_q   <= err_q;
							out_word_q   <= (err_q == lcfd_pkg::ERR_DESYNC)
								? lcfd_pkg::WORD_DESYNC : lcfd_pkg::WORD_TOO_LONG;
							out_probe_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_value = out_sample_q;
	assign out_ch.error_code   = out_code_q;
	assign out_ch.report_word  = out_word_q;
	assign out_ch.probe_valid  = out_probe_q;

endmodule

`default_nettype wire

### sv/lcfd_checker.sv
// Port-level assertions for the frame decoder top level, and the bind that attaches them.
// Depends on lcfd_pkg for the error codes and report words.
`timescale 1ns / 1ps
`default_nettype none

module lcfd_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_func,
	input wire logic        in_end_of_round,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [24:0] out_sample_value,
	input wire logic [1:0]  out_error_code,
	input wire logic [31:0] out_report_word,
	input wire logic        out_probe_valid
);

	// A waiting word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped before it was taken");

	// A waiting word keeps its report and code.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_report_word) && $stable(out_error_code))
		else $error("output word changed while stalled");

	// A restart or a frame that does not close a round makes no word.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_func || !in_end_of_round) |=> !$rose(out_valid))
		else $error("word produced by an item that closes no round");

	// An error report carries a zero sample, no probe and its error word.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_error_code != lcfd_pkg::ERR_NONE) |->
		(out_sample_value == 25'd0) && !out_probe_valid &&
		((out_report_word == lcfd_pkg::WORD_DESYNC) ||
		(out_report_word == lcfd_pkg::WORD_TOO_LONG)))
		else $error("error report fields disagree");

	// A clean report word is the sign-extended sample.
	a_ok_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_error_code == lcfd_pkg::ERR_NONE) |->
		(out_report_word[24:0] == out_sample_value) &&
		(out_report_word[31:25] == {7{out_sample_value[24]}}))
		else $error("report word does not match the fused sample");

endmodule

bind load_cell_frame_decode_fuse_top lcfd_port_checks u_lcfd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_func          (in_ch.func),
	.in_end_of_round  (in_ch.end_of_round),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_sample_value (out_ch.sample_value),
	.out_error_code   (out_ch.error_code),
	.out_report_word  (out_ch.report_word),
	.out_probe_valid  (out_ch.probe_valid)
);

`default_nettype wire
